>>> hdl/rbsor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsor_pkg
// Shared types, codes and fixed-point helpers of the red-black SOR solver.
// ----------------------------------------------------------------------------
package rbsor_pkg;

    localparam int P_MAX_X      = 32;
    localparam int P_MAX_Y      = 32;
    localparam int P_MAX_Z      = 32;
    localparam int P_VALUE_BITS = 32;

    localparam int VB_EFF = (P_VALUE_BITS > 32) ? 32 : P_VALUE_BITS;
    localparam logic signed [39:0] V_MAX = (40'sd1 <<< (VB_EFF - 1)) - 40'sd1;
    localparam logic signed [39:0] V_MIN = -V_MAX - 40'sd1;
    localparam logic signed [31:0] V_ONE =
        (V_MAX < 40'sd65536) ? 32'(V_MAX) : 32'sd65536;

    // item operations
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SOLVE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET = 3'd0;
    localparam logic [2:0] CFG_OMEGA  = 3'd1;
    localparam logic [2:0] CFG_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_TOL    = 3'd3;
    localparam logic [2:0] CFG_STEP   = 3'd4;
    localparam logic [2:0] CFG_GX     = 3'd5;
    localparam logic [2:0] CFG_GY     = 3'd6;
    localparam logic [2:0] CFG_GZ     = 3'd7;

    typedef struct packed {
        logic [1:0]         operation;
        logic [14:0]        node_index;
        logic [31:0]        node_coefficient;
        logic signed [31:0] node_source;
        logic [7:0]         electrode_id;
    } t_item;

    typedef struct packed {
        logic signed [31:0] node_potential;
        logic [15:0]        iterations_used;
        logic               result_kind;
    } t_result;

    typedef struct packed {
        logic [7:0]  target_electrode;
        logic [14:0] relaxation_factor;
        logic [15:0] iteration_limit;
        logic [31:0] tolerance;
        logic [31:0] step_squared;
        logic [5:0]  grid_x;
        logic [5:0]  grid_y;
        logic [5:0]  grid_z;
    } t_cfg;

    typedef struct packed {
        logic load;        // load item transfer
        logic rd_item;     // read item transfer
        logic rd_en;       // node sweep read
        logic rd_center;   // the read is the centre node
        logic init_rd;     // start-potential sweep read
        logic div_start;
        logic relax;
        logic wr_upd;
        logic max_clr;
        logic solve_done;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic div_busy;
        logic lt_tol;
    } t_dp_stat;

    function automatic logic signed [31:0] sat_val(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > V_MAX) begin
            r = 32'(V_MAX);
        end else if (v < V_MIN) begin
            r = 32'(V_MIN);
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

>>> hdl/red_black_sor_poisson_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_black_sor_poisson_solver
// 3-D red-black SOR Poisson solver in Q16.16, electric or magnetic mode.
// ----------------------------------------------------------------------------
// Items enter on i_item with start; a transfer happens when start is high and
// busy is low. Load items write one node's coefficient, source and electrode
// id, one per cycle. Read items return the node potential in the next cycle on
// o_result with o_result_valid high for a single cycle.
// A solve item raises busy: a start-potential sweep over all nodes, then
// per interior node the reads and accumulation (seven store reads on the
// single read port), plus division and relaxation for nodes that are
// updated. The solve result (iteration count) is strobed the cycle busy
// falls. The receiver cannot stall; results are never held.
// Configuration writes go over i_cfg_valid/o_cfg_ready (always ready) and
// must happen while busy is low. Reset restores register defaults and idles
// the block; store contents are not cleared.
// ----------------------------------------------------------------------------
module red_black_sor_poisson_solver
    import rbsor_pkg::*;
#(
    parameter int MAX_X = P_MAX_X,
    parameter int MAX_Y = P_MAX_Y,
    parameter int MAX_Z = P_MAX_Z
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_result_valid,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(DEPTH);

    t_cfg          r_cfg;
    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [15:0]   iter;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_electrode  <= 8'd0;
            r_cfg.relaxation_factor <= 15'd16384;
            r_cfg.iteration_limit   <= 16'd1000;
            r_cfg.tolerance         <= 32'd66;
            r_cfg.step_squared      <= 32'd65536;
            r_cfg.grid_x            <= 6'd32;
            r_cfg.grid_y            <= 6'd32;
            r_cfg.grid_z            <= 6'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TARGET: r_cfg.target_electrode  <= i_cfg_data[7:0];
                CFG_OMEGA:  r_cfg.relaxation_factor <= i_cfg_data[14:0];
                CFG_LIMIT:  r_cfg.iteration_limit   <= i_cfg_data[15:0];
                CFG_TOL:    r_cfg.tolerance         <= i_cfg_data;
                CFG_STEP:   r_cfg.step_squared      <= i_cfg_data;
                CFG_GX:     r_cfg.grid_x            <= i_cfg_data[5:0];
                CFG_GY:     r_cfg.grid_y            <= i_cfg_data[5:0];
                CFG_GZ:     r_cfg.grid_z            <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    rbsor_ctrl #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z),
        .AW    (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .i_stat    (stat),
        .o_busy    (busy),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr),
        .o_iter    (iter)
    );

    rbsor_dp #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .i_cmd     (cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_iter    (iter),
        .o_stat    (stat),
        .o_valid   (o_result_valid),
        .o_result  (o_result)
    );

endmodule

>>> hdl/rbsor_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsor_ctrl
// Sequencer: item decode, start-potential sweep, red-black node walk and
// per-node step sequencing of the datapath.
// ----------------------------------------------------------------------------
module rbsor_ctrl
    import rbsor_pkg::*;
#(
    parameter int MAX_X = P_MAX_X,
    parameter int MAX_Y = P_MAX_Y,
    parameter int MAX_Z = P_MAX_Z,
    parameter int AW    = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_item         i_item,
    input  t_cfg          i_cfg,
    input  t_dp_stat      i_stat,
    output logic          o_busy,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_rd_addr,
    output logic [AW-1:0] o_wr_addr,
    output logic [15:0]   o_iter
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_INITW   = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_NODE    = 4'd4;
    localparam logic [3:0] S_DRAIN   = 4'd5;
    localparam logic [3:0] S_DECIDE  = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;
    localparam logic [3:0] S_RELAX   = 4'd8;
    localparam logic [3:0] S_WRITE   = 4'd9;
    localparam logic [3:0] S_ITEREND = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0]  r_state, n_state;
    logic [17:0] r_n, n_n;
    logic [6:0]  r_i, n_i;
    logic [5:0]  r_j, n_j, r_k, n_k;
    logic        r_col, n_col;
    logic [2:0]  r_t, n_t;
    logic        r_w, n_w;
    logic [15:0] r_iter, n_iter;

    logic [5:0]  gx, gy, gz;
    logic [11:0] gxy, kg;
    logic [17:0] total, c18, a18;
    logic [16:0] iter_inc;

    always_comb begin
        gx = (i_cfg.grid_x < 6'd3) ? 6'd3 :
             ((32'(i_cfg.grid_x) > MAX_X) ? 6'(MAX_X) : i_cfg.grid_x);
        gy = (i_cfg.grid_y < 6'd3) ? 6'd3 :
             ((32'(i_cfg.grid_y) > MAX_Y) ? 6'(MAX_Y) : i_cfg.grid_y);
        gz = (i_cfg.grid_z < 6'd3) ? 6'd3 :
             ((32'(i_cfg.grid_z) > MAX_Z) ? 6'(MAX_Z) : i_cfg.grid_z);
        gxy   = 12'(gx) * 12'(gy);
        total = 18'(gxy) * 18'(gz);
        kg    = 12'(r_k) * 12'(gy) + 12'(r_j);
        c18   = 18'(kg) * 18'(gx) + 18'(r_i);
        case (r_t)
            3'd1:    a18 = c18 - 18'd1;
            3'd2:    a18 = c18 + 18'd1;
            3'd3:    a18 = c18 - 18'(gx);
            3'd4:    a18 = c18 + 18'(gx);
            3'd5:    a18 = c18 - 18'(gxy);
            3'd6:    a18 = c18 + 18'(gxy);
            default: a18 = c18;
        endcase
        iter_inc = 17'(r_iter) + 17'd1;
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_col   = r_col;
        n_t     = r_t;
        n_w     = r_w;
        n_iter  = r_iter;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_item.operation)
                        OP_LOAD:  o_cmd.load    = 1'b1;
                        OP_READ:  o_cmd.rd_item = 1'b1;
                        OP_SOLVE: begin
                            n_n     = '0;
                            n_state = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init_rd = 1'b1;
                if (r_n == total - 18'd1) begin
                    n_state = S_INITW;
                end else begin
                    n_n = r_n + 18'd1;
                end
            end
            S_INITW: begin
                n_iter = '0;
                if (i_cfg.iteration_limit == 16'd0) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.max_clr = 1'b1;
                    n_col   = 1'b0;
                    n_k     = 6'd1;
                    n_j     = 6'd1;
                    n_i     = 7'd2;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // walk to the next node of this colour, one row step a cycle
                if (r_i + 7'd1 < 7'(gx)) begin
                    n_t     = '0;
                    n_state = S_NODE;
                end else if (7'(r_j) + 7'd2 < 7'(gy)) begin
                    n_j = r_j + 6'd1;
                    n_i = 7'd1 + {6'd0, r_j[0] ^ r_k[0] ^ r_col};
                end else if (7'(r_k) + 7'd2 < 7'(gz)) begin
                    n_k = r_k + 6'd1;
                    n_j = 6'd1;
                    n_i = 7'd1 + {6'd0, ~(r_k[0] ^ r_col)};
                end else if (!r_col) begin
                    n_col = 1'b1;
                    n_k   = 6'd1;
                    n_j   = 6'd1;
                    n_i   = 7'd1;
                end else begin
                    n_state = S_ITEREND;
                end
            end
            S_NODE: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_center = (r_t == 3'd0);
                if (r_t == 3'd6) begin
                    n_w     = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_t = r_t + 3'd1;
                end
            end
            S_DRAIN: begin
                n_w = 1'b1;
                if (r_w) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.skip) begin
                    n_i     = r_i + 7'd2;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_RELAX;
                end
            end
            S_RELAX: begin
                o_cmd.relax = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_upd = 1'b1;
                n_i     = r_i + 7'd2;
                n_state = S_SCAN;
            end
            S_ITEREND: begin
                n_iter = iter_inc[15:0];
                if (i_stat.lt_tol || iter_inc[15:0] == i_cfg.iteration_limit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.max_clr = 1'b1;
                    n_col   = 1'b0;
                    n_k     = 6'd1;
                    n_j     = 6'd1;
                    n_i     = 7'd2;
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                o_cmd.solve_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_col   <= 1'b0;
            r_t     <= '0;
            r_w     <= 1'b0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_col   <= n_col;
            r_t     <= n_t;
            r_w     <= n_w;
            r_iter  <= n_iter;
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_rd_addr = (r_state == S_IDLE) ? AW'(i_item.node_index) :
                       (r_state == S_INIT) ? AW'(r_n) : AW'(a18);
    assign o_wr_addr = AW'(c18);
    assign o_iter    = r_iter;

endmodule

>>> hdl/rbsor_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsor_dp
// Node stores, face-weight accumulator, radix-2 divider, relaxation step
// and result register.
// ----------------------------------------------------------------------------
module rbsor_dp
    import rbsor_pkg::*;
#(
    parameter int DEPTH = P_MAX_X * P_MAX_Y * P_MAX_Z,
    parameter int AW    = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_item         i_item,
    input  t_cfg          i_cfg,
    input  t_dp_cmd       i_cmd,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_iter,
    output t_dp_stat      o_stat,
    output logic          o_valid,
    output t_result       o_result
);

    logic [71:0]        r_aux [DEPTH];   // {coefficient, source, electrode}
    logic signed [31:0] r_pot [DEPTH];
    logic [71:0]        r_aux_q;
    logic signed [31:0] r_pot_q;

    logic               item_ok, electric;
    logic [31:0]        coef_q, w1, mul_b;
    logic signed [31:0] src_q, mul_a, init_val, star, new_val;
    logic [7:0]         elec_q;

    logic               r_s1_v, r_s1_c, r_s2_v, r_s2_c;
    logic [31:0]        r_cn, r_w2;
    logic [7:0]         r_elec;
    logic signed [31:0] r_old;
    logic signed [64:0] r_prod;
    logic signed [48:0] term;
    logic signed [51:0] r_num;
    logic [34:0]        r_den;

    logic               r_init_v;
    logic [AW-1:0]      r_init_addr;

    logic               r_dbusy, r_dload, r_neg, r_ovf;
    logic [51:0]        r_m;
    logic [34:0]        r_rem;
    logic [31:0]        r_low;
    logic [4:0]         r_dcnt;
    logic [35:0]        rem_sh;
    logic               ge;

    logic signed [39:0] sval;
    logic signed [33:0] diff;
    logic signed [49:0] r_dprod;
    logic signed [35:0] d;
    logic [35:0]        ad, r_maxd;

    logic               r_rd_pend, r_rd_ok, r_sv_pend;
    logic [15:0]        r_sv_iter;

    assign item_ok  = (32'(i_item.node_index) < 32'(DEPTH));
    assign electric = (i_cfg.target_electrode != 8'd0);
    assign coef_q   = r_aux_q[71:40];
    assign src_q    = $signed(r_aux_q[39:8]);
    assign elec_q   = r_aux_q[7:0];
    assign init_val = (electric && elec_q == i_cfg.target_electrode) ? V_ONE : 32'sd0;

    // node stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && item_ok) begin
            r_aux[AW'(i_item.node_index)] <= {i_item.node_coefficient,
                                              i_item.node_source, i_item.electrode_id};
        end
        r_aux_q <= r_aux[i_rd_addr];
        r_pot_q <= r_pot[i_rd_addr];
        if (r_init_v) begin
            r_pot[r_init_addr] <= init_val;
        end else if (i_cmd.wr_upd) begin
            r_pot[i_wr_addr] <= new_val;
        end
    end

    // stage 1: face weight and one product; stage 2: accumulate
    always_comb begin
        w1    = 32'((33'(r_cn) + 33'(coef_q)) >> 1);
        mul_a = r_s1_c ? src_q : r_pot_q;
        mul_b = r_s1_c ? i_cfg.step_squared : w1;
        term  = 49'(r_prod >>> 16);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 65'(mul_a) * $signed({1'b0, mul_b});
        r_w2   <= r_s1_c ? 32'd0 : w1;
        if (r_s1_v && r_s1_c) begin
            r_cn   <= coef_q;
            r_elec <= elec_q;
            r_old  <= r_pot_q;
        end
        if (r_s2_v) begin
            if (r_s2_c) begin
                r_num <= electric ? 52'sd0 : 52'(term);
                r_den <= '0;
            end else begin
                r_num <= r_num + 52'(term);
                r_den <= r_den + 35'(r_w2);
            end
        end
        if (i_cmd.init_rd) begin
            r_init_addr <= i_rd_addr;
        end
    end

    // divider: floor(|num| * 2^16 / den), one quotient bit a cycle
    always_comb begin
        rem_sh = {r_rem, r_low[31]};
        ge     = (rem_sh >= 36'(r_den));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= r_num[51];
            r_m   <= r_num[51] ? 52'(-r_num) : 52'(r_num);
        end
        if (r_dload) begin
            r_ovf  <= (r_m >= 52'({r_den, 16'd0}));
            r_rem  <= 35'(r_m >> 16);
            r_low  <= {r_m[15:0], 16'd0};
            r_dcnt <= '0;
        end else if (r_dbusy) begin
            r_rem  <= ge ? 35'(rem_sh - 36'(r_den)) : 35'(rem_sh);
            r_low  <= {r_low[30:0], ge};
            r_dcnt <= r_dcnt + 5'd1;
        end
    end

    // relaxation: d = floor(omega * (star - old) / 2^14)
    always_comb begin
        sval    = r_neg ? -40'sd1 * $signed({8'd0, r_low}) : $signed({8'd0, r_low});
        star    = r_ovf ? (r_neg ? 32'(V_MIN) : 32'(V_MAX)) : sat_val(sval);
        diff    = 34'(star) - 34'(r_old);
        d       = 36'(r_dprod >>> 14);
        ad      = d[35] ? 36'(-d) : 36'(d);
        new_val = sat_val(40'(r_old) + 40'(d));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.relax) begin
            r_dprod <= 50'(diff) * $signed({1'b0, i_cfg.relaxation_factor});
        end
        r_sv_iter <= i_iter;
        if (i_cmd.rd_item) begin
            r_rd_ok <= item_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s1_c    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s2_c    <= 1'b0;
            r_init_v  <= 1'b0;
            r_dbusy   <= 1'b0;
            r_dload   <= 1'b0;
            r_maxd    <= '0;
            r_rd_pend <= 1'b0;
            r_sv_pend <= 1'b0;
        end else begin
            r_s1_v    <= i_cmd.rd_en;
            r_s1_c    <= i_cmd.rd_center;
            r_s2_v    <= r_s1_v;
            r_s2_c    <= r_s1_c;
            r_init_v  <= i_cmd.init_rd;
            r_rd_pend <= i_cmd.rd_item;
            r_sv_pend <= i_cmd.solve_done;
            r_dload   <= i_cmd.div_start;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
            end else if (!r_dload && r_dbusy && r_dcnt == 5'd31) begin
                r_dbusy <= 1'b0;
            end
            if (i_cmd.max_clr) begin
                r_maxd <= '0;
            end else if (i_cmd.wr_upd && ad > r_maxd) begin
                r_maxd <= ad;
            end
        end
    end

    assign o_stat.skip     = (electric && r_elec != 8'd0) || (r_den == 35'd0);
    assign o_stat.div_busy = r_dbusy;
    assign o_stat.lt_tol   = (r_maxd < 36'(i_cfg.tolerance));

    assign o_valid = r_rd_pend | r_sv_pend;
    always_comb begin
        if (r_sv_pend) begin
            o_result.node_potential  = '0;
            o_result.iterations_used = r_sv_iter;
            o_result.result_kind     = KIND_SOLVE;
        end else begin
            o_result.node_potential  = r_rd_ok ? r_pot_q : 32'sd0;
            o_result.iterations_used = '0;
            o_result.result_kind     = KIND_READ;
        end
    end

endmodule

>>> hdl/rbsor_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsor_chk
// Port-level checks of item and result sequencing.
// ----------------------------------------------------------------------------
module rbsor_chk
    import rbsor_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_item   i_item,
    input logic    o_result_valid,
    input t_result o_result
);

    logic acc;
    assign acc = start && !busy;

    // a read transfer gives read data in the next cycle
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_item.operation == OP_READ |=>
            o_result_valid && o_result.result_kind == KIND_READ)
        else $error("read result missing");

    // loads and unused codes give no result
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_item.operation == OP_LOAD || i_item.operation == OP_UNUSED) |=>
            !o_result_valid)
        else $error("spurious result");

    // a solve transfer makes the block busy
    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_item.operation == OP_SOLVE |=> busy)
        else $error("solve did not start");

    // end of a solve comes with its result
    a_solve_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid && o_result.result_kind == KIND_SOLVE)
        else $error("solve result missing");

endmodule

bind red_black_sor_poisson_solver rbsor_chk u_rbsor_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_item         (i_item),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

>>> sim/red_black_sor_poisson_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_black_sor_poisson_solver_tb
// Self-checking bench for the red-black SOR solver.
// ----------------------------------------------------------------------------
// Node loads, solves and potential reads are driven over the start/busy port,
// with random gaps. A scoreboard class keeps its own copy of the registers and
// node stores, reruns every solve in fixed point and checks each strobed
// result in order. The registers are rewritten between solve sequences, and
// the extremes of every register but the grid sizes are covered.
// ----------------------------------------------------------------------------
module red_black_sor_poisson_solver_tb;
    import rbsor_pkg::*;

    localparam int STORE_DEPTH = P_MAX_X * P_MAX_Y * P_MAX_Z;
    localparam int TARGET_ITEMS = 950;

    class solver_scoreboard;
        bit [7:0]  target;
        bit [14:0] omega;
        bit [15:0] iter_limit;
        bit [31:0] tol;
        bit [31:0] step_sq;
        bit [5:0]  gx_reg, gy_reg, gz_reg;

        int        pot[STORE_DEPTH];
        bit [31:0] coef[STORE_DEPTH];
        int        src[STORE_DEPTH];
        bit [7:0]  elec[STORE_DEPTH];

        t_result   expected_q[$];
        int        errors;
        int        n_loads, n_solves, n_reads, n_zero_iter, peak_iters;

        function new();
            target     = 8'd0;
            omega      = 15'd16384;
            iter_limit = 16'd1000;
            tol        = 32'd66;
            step_sq    = 32'd65536;
            gx_reg     = 6'd32;
            gy_reg     = 6'd32;
            gz_reg     = 6'd32;
        endfunction

        function void write_reg(bit [2:0] idx, bit [31:0] data);
            case (idx)
                CFG_TARGET: target     = data[7:0];
                CFG_OMEGA:  omega      = data[14:0];
                CFG_LIMIT:  iter_limit = data[15:0];
                CFG_TOL:    tol        = data;
                CFG_STEP:   step_sq    = data;
                CFG_GX:     gx_reg     = data[5:0];
                CFG_GY:     gy_reg     = data[5:0];
                CFG_GZ:     gz_reg     = data[5:0];
                default: ;
            endcase
        endfunction

        function int unsigned dim(bit [5:0] v, int unsigned hi);
            if (v < 3) return 3;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned node_total();
            return dim(gx_reg, P_MAX_X) * dim(gy_reg, P_MAX_Y) * dim(gz_reg, P_MAX_Z);
        endfunction

        // floor(a * b / 2^sh)
        function longint mul_floor(longint a, longint unsigned b, int sh);
            longint unsigned m, p;
            m = (a < 0) ? -a : a;
            p = m * b;
            if (a < 0) return -longint'((p + ((64'd1 << sh) - 1)) >> sh);
            return longint'(p >> sh);
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function bit [15:0] relax_grid();
            int unsigned gx, gy, gz, total, n, iter, colour, i, j, k, c;
            int unsigned nb[6];
            longint unsigned cn, w, denom, m, q, r, mag, ad, maxd;
            longint numer, star, diff, d;
            bit electric;
            gx = dim(gx_reg, P_MAX_X);
            gy = dim(gy_reg, P_MAX_Y);
            gz = dim(gz_reg, P_MAX_Z);
            total = gx * gy * gz;
            electric = (target != 0);
            for (n = 0; n < total; n++)
                pot[n] = (electric && elec[n] == target) ? 65536 : 0;
            for (iter = 0; iter < iter_limit; iter++) begin
                maxd = 0;
                for (colour = 0; colour < 2; colour++)
                for (k = 1; k + 1 < gz; k++)
                for (j = 1; j + 1 < gy; j++)
                for (i = 1 + ((j + k + colour + 1) & 1); i + 1 < gx; i += 2) begin
                    c = (k * gy + j) * gx + i;
                    if (electric && elec[c] != 0) continue;
                    nb[0] = c - 1;       nb[1] = c + 1;
                    nb[2] = c - gx;      nb[3] = c + gx;
                    nb[4] = c - gx * gy; nb[5] = c + gx * gy;
                    cn = coef[c];
                    denom = 0;
                    numer = 0;
                    for (int t = 0; t < 6; t++) begin
                        w = (cn + longint'(coef[nb[t]])) >> 1;
                        denom += w;
                        numer += mul_floor(pot[nb[t]], w, 16);
                    end
                    if (!electric) numer += mul_floor(src[c], step_sq, 16);
                    if (denom == 0) continue;
                    m = (numer < 0) ? -numer : numer;
                    q = m / denom;
                    r = m % denom;
                    if (q >= 64'd1 << 32) mag = 64'd1 << 48;
                    else mag = (q << 16) | ((r << 16) / denom);
                    star = clip((numer < 0) ? -longint'(mag) : longint'(mag));
                    diff = star - pot[c];
                    d = mul_floor(diff, omega, 14);
                    pot[c] = int'(clip(pot[c] + d));
                    ad = (d < 0) ? -d : d;
                    if (ad > maxd) maxd = ad;
                end
                if (maxd < tol) begin
                    iter++;
                    break;
                end
            end
            return iter[15:0];
        endfunction

        function void note_item(t_item it);
            t_result e;
            e = '0;
            case (it.operation)
                OP_LOAD: begin
                    coef[it.node_index] = it.node_coefficient;
                    src[it.node_index]  = it.node_source;
                    elec[it.node_index] = it.electrode_id;
                    n_loads++;
                end
                OP_SOLVE: begin
                    e.iterations_used = relax_grid();
                    e.result_kind = KIND_SOLVE;
                    if (e.iterations_used == 0) n_zero_iter++;
                    if (e.iterations_used > peak_iters) peak_iters = e.iterations_used;
                    expected_q.push_back(e);
                    n_solves++;
                end
                OP_READ: begin
                    e.node_potential = pot[it.node_index];
                    e.result_kind = KIND_READ;
                    expected_q.push_back(e);
                    n_reads++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            if (got.node_potential !== e.node_potential
                || got.iterations_used !== e.iterations_used
                || got.result_kind !== e.result_kind) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch kind %b/%b potential %h/%h iterations %0d/%0d (exp/act)",
                             $time, e.result_kind, got.result_kind, e.node_potential,
                             got.node_potential, e.iterations_used, got.iterations_used);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_result_valid;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    solver_scoreboard sb = new();
    bit pot_ok[STORE_DEPTH];
    int items_sent;
    bit no_gaps;

    red_black_sor_poisson_solver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result);
    end

    initial begin
        #40_000_000;
        $display("** red_black_sor_poisson_solver: FAILED **");
        $finish;
    end

    task automatic send_item(t_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        if (it.operation != OP_UNUSED) items_sent++;
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every transfer to come back, plus the load latency
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_node(int unsigned idx, int style);
        t_item it;
        int pick;
        it.operation  = OP_LOAD;
        it.node_index = idx[14:0];
        pick = $urandom_range(0, 9);
        case (style)
            1: it.node_coefficient = '0;
            2: it.node_coefficient = $urandom();
            default: it.node_coefficient = (pick == 0) ? 32'd0 : $urandom_range(16384, 262143);
        endcase
        it.node_source = (pick < 3) ? $urandom() : $urandom_range(0, 131071) - 65536;
        pick = $urandom_range(0, 19);
        if (pick < 14) it.electrode_id = 8'd0;
        else if (pick < 17) it.electrode_id = sb.target;
        else it.electrode_id = $urandom_range(1, 255);
        send_item(it);
    endtask

    task automatic noise_item(int unsigned total);
        t_item it;
        it = t_item'({$urandom(), $urandom(), $urandom()});
        case ($urandom_range(0, 2))
            0: it.operation = OP_UNUSED;
            1: begin
                it.operation  = OP_LOAD;
                it.node_index = $urandom_range(total, STORE_DEPTH - 1);
            end
            default: begin
                it.operation  = OP_READ;
                it.node_index = $urandom_range(0, total - 1);
            end
        endcase
        if (it.operation != OP_READ || pot_ok[it.node_index]) send_item(it);
    endtask

    task automatic run_sequence(int style);
        t_item it;
        int unsigned total;
        total = sb.node_total();
        for (int unsigned n = 0; n < total; n++) begin
            if ($urandom_range(0, 15) == 0) noise_item(total);
            load_node(n, style);
        end
        it = t_item'({$urandom(), $urandom(), $urandom()});
        it.operation = OP_SOLVE;
        send_item(it);
        for (int unsigned n = 0; n < total; n++) pot_ok[n] = 1'b1;
        repeat ($urandom_range(4, 12)) begin
            it = t_item'({$urandom(), $urandom(), $urandom()});
            it.operation  = OP_READ;
            it.node_index = $urandom_range(0, total - 1);
            send_item(it);
            if ($urandom_range(0, 5) == 0) noise_item(total);
        end
    endtask

    task automatic set_regs(logic [7:0] tg, logic [14:0] om, logic [15:0] lim,
                            logic [31:0] tl, logic [31:0] st,
                            logic [5:0] gx, logic [5:0] gy, logic [5:0] gz);
        cfg_write(CFG_TARGET, 32'(tg));
        cfg_write(CFG_OMEGA,  32'(om));
        cfg_write(CFG_LIMIT,  32'(lim));
        cfg_write(CFG_TOL,    tl);
        cfg_write(CFG_STEP,   st);
        cfg_write(CFG_GX,     32'(gx));
        cfg_write(CFG_GY,     32'(gy));
        cfg_write(CFG_GZ,     32'(gz));
    endtask

    initial begin
        t_item it;
        int seq;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        no_gaps     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: register defaults with the smallest grid, extreme loads outside the grid, unused code
        set_regs(8'd0, 15'd16384, 16'd1000, 32'd66, 32'd65536, 6'd3, 6'd3, 6'd3);
        it = '0;
        it.operation = OP_UNUSED;
        send_item(it);
        it = '1;
        it.operation = OP_LOAD;
        it.node_source = 32'sh8000_0000;
        send_item(it);
        it.node_index = 15'd100;
        it.node_source = 32'sh7fff_ffff;
        it.node_coefficient = '0;
        it.electrode_id = '0;
        send_item(it);

        seq = 0;
        while (items_sent < TARGET_ITEMS) begin
            drain();
            no_gaps = ($urandom_range(0, 3) == 0);
            case (seq)
                0: ;
                1: set_regs(8'd255, 15'd32767, 16'd20, 32'd0, 32'd0, 6'd63, 6'd0, 6'd3);
                2: set_regs(8'd0, 15'd0, 16'd0, 32'd1, 32'hffff_ffff, 6'd4, 6'd3, 6'd5);
                3: set_regs(8'd7, 15'd20000, 16'd65535, 32'hffff_ffff, 32'd1,
                            6'd5, 6'd4, 6'd3);
                default: set_regs($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255)),
                                  $urandom_range(0, 32767), $urandom_range(1, 10),
                                  $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000),
                                  $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 131072),
                                  $urandom_range(0, 5), $urandom_range(0, 5),
                                  $urandom_range(0, 5));
            endcase
            run_sequence((seq == 4) ? 1 : (seq % 5 == 3) ? 2 : 0);
            seq++;
        end

        start <= 1'b0;
        fork
            while (sb.expected_q.size() != 0) @(posedge i_clk);
            repeat (2_000_000) @(posedge i_clk);
        join_any
        disable fork;
        repeat (50) @(posedge i_clk);
        $display("Ran %0d solve sequences: %0d loads, %0d solves (%0d with no sweep, up to %0d iterations), %0d reads.",
                 seq, sb.n_loads, sb.n_solves, sb.n_zero_iter, sb.peak_iters, sb.n_reads);
        $display("Mismatches: %0d, results outstanding: %0d.", sb.errors, sb.expected_q.size());
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** red_black_sor_poisson_solver: PASSED **");
        end else begin
            $display("** red_black_sor_poisson_solver: FAILED **");
        end
        $finish;
    end

endmodule
